[design/kbq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard controller byte queue: shared definitions
// Command codes, port offsets, protocol bytes and the control bundle that
// the sequencer sends to the datapath.
// ----------------------------------------------------------------------------
package kbq_pkg;

    localparam logic [1:0] CMD_KEY   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_POLL  = 2'd3;

    localparam logic [2:0] PORT_DATA   = 3'd0;
    localparam logic [2:0] PORT_SYSCTL = 3'd1;
    localparam logic [2:0] PORT_STATUS = 3'd4;

    localparam logic [7:0] ANSWER_ACK      = 8'hFA;
    localparam logic [7:0] ANSWER_SELFTEST = 8'hAA;
    localparam logic [7:0] KCMD_SELFTEST   = 8'h01;
    localparam logic [7:0] KCMD_SET_LED    = 8'hED;
    localparam logic [7:0] KCMD_DISABLE    = 8'hF5;
    localparam logic [7:0] CCMD_ENABLE     = 8'hAE;
    localparam logic [7:0] SPEAKER_MASK    = 8'h20;
    localparam logic [7:0] READ_IDLE       = 8'hFF;

    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage
`default_nettype wire

[design/kbq_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module kbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

[design/kbq_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard controller byte queue: sequencer
// Takes a request when idle, executes it in the execute state, then returns to idle.
// ----------------------------------------------------------------------------
module kbq_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    output kbq_pkg::t_dp_cmd    o_dp_cmd
);
    import kbq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy             = (r_state == S_EXEC);
    assign o_dp_cmd.capture = (r_state == S_IDLE) && start;
    assign o_dp_cmd.execute = (r_state == S_EXEC);

endmodule
`default_nettype wire

[design/kbq_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard controller byte queue: datapath
// Request registers, ring queue pointers, interface and control state, and
// the registered result.
// ----------------------------------------------------------------------------
module kbq_datapath #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  kbq_pkg::t_dp_cmd       i_dp_cmd,
    input  wire logic [1:0]        i_command,
    input  wire logic [2:0]        i_port_offset,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic              i_speaker_active,
    output logic                   o_done,
    output logic      [7:0]        o_read_data,
    output logic                   o_irq_assert,
    output logic                   o_irq_clear,
    output logic                   o_gate_update,
    output logic                   o_timer_gate,
    output logic                   o_speaker_on,
    output logic                   o_byte_dropped
);
    import kbq_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    function automatic logic [PTR_W-1:0] f_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
        return n;
    endfunction

    logic [1:0]       r_command;
    logic [2:0]       r_port_offset;
    logic [7:0]       r_data_byte;
    logic             r_speaker_active;

    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic             r_if_en;
    logic             n_if_en;
    logic             r_led_pend;
    logic             n_led_pend;
    logic [7:0]       r_sysctl;
    logic [7:0]       n_sysctl;

    logic             r_done;
    logic [7:0]       r_read_data;
    logic [7:0]       n_read_data;
    logic             r_irq_assert;
    logic             n_irq_assert;
    logic             r_irq_clear;
    logic             n_irq_clear;
    logic             r_gate_update;
    logic             n_gate_update;
    logic             r_byte_dropped;
    logic             n_byte_dropped;

    logic             enq;
    logic [7:0]       enq_byte;
    logic             ram_we;
    logic [7:0]       ram_rdata;
    logic             has_data;
    logic [PTR_W-1:0] wr_next;

    assign has_data = (r_rd_ptr != r_wr_ptr);
    assign wr_next  = f_next(r_wr_ptr);

    always_comb begin
        n_rd_ptr       = r_rd_ptr;
        n_wr_ptr       = r_wr_ptr;
        n_if_en        = r_if_en;
        n_led_pend     = r_led_pend;
        n_sysctl       = r_sysctl;
        n_read_data    = READ_IDLE;
        n_irq_assert   = 1'b0;
        n_irq_clear    = 1'b0;
        n_gate_update  = 1'b0;
        n_byte_dropped = 1'b0;
        enq            = 1'b0;
        enq_byte       = ANSWER_ACK;
        ram_we         = 1'b0;
        if (i_dp_cmd.execute) begin
            unique case (r_command)
                CMD_KEY: begin
                    enq      = r_if_en;
                    enq_byte = r_data_byte;
                end
                CMD_READ: begin
                    unique case (r_port_offset)
                        PORT_DATA: begin
                            n_irq_clear = 1'b1;
                            if (has_data) begin
                                n_read_data = ram_rdata;
                                n_rd_ptr    = f_next(r_rd_ptr);
                            end
                        end
                        PORT_SYSCTL: begin
                            n_read_data = r_sysctl |
                                          (r_speaker_active ? SPEAKER_MASK : 8'h00);
                        end
                        PORT_STATUS: begin
                            n_read_data = {7'd0, has_data};
                        end
                        default: begin
                            n_read_data = READ_IDLE;
                        end
                    endcase
                end
                CMD_WRITE: begin
                    unique case (r_port_offset)
                        PORT_DATA: begin
                            priority if (r_led_pend) begin
                                n_led_pend = 1'b0;
                                enq        = 1'b1;
                            end else if (r_data_byte == KCMD_SELFTEST) begin
                                enq      = 1'b1;
                                enq_byte = ANSWER_SELFTEST;
                            end else if (r_data_byte == KCMD_SET_LED) begin
                                n_led_pend = 1'b1;
                                enq        = 1'b1;
                            end else if (r_data_byte == KCMD_DISABLE) begin
                                n_irq_clear = 1'b1;
                                n_rd_ptr    = r_wr_ptr;
                                n_if_en     = 1'b0;
                                enq         = 1'b1;
                            end else begin
                                enq = 1'b0;
                            end
                        end
                        PORT_SYSCTL: begin
                            n_sysctl      = r_data_byte;
                            n_gate_update = 1'b1;
                        end
                        PORT_STATUS: begin
                            if (r_data_byte == CCMD_ENABLE) begin
                                n_if_en = 1'b1;
                            end
                        end
                        default: begin
                            n_if_en = r_if_en;
                        end
                    endcase
                end
                CMD_POLL: begin
                    n_irq_assert = has_data;
                end
                default: begin
                    enq = 1'b0;
                end
            endcase
            if (enq) begin
                if (wr_next == n_rd_ptr) begin
                    n_byte_dropped = 1'b1;
                end else begin
                    ram_we   = 1'b1;
                    n_wr_ptr = wr_next;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.capture) begin
            r_command        <= i_command;
            r_port_offset    <= i_port_offset;
            r_data_byte      <= i_data_byte;
            r_speaker_active <= i_speaker_active;
        end
        r_read_data    <= n_read_data;
        r_irq_assert   <= n_irq_assert;
        r_irq_clear    <= n_irq_clear;
        r_gate_update  <= n_gate_update;
        r_byte_dropped <= n_byte_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_if_en    <= 1'b1;
            r_led_pend <= 1'b0;
            r_sysctl   <= 8'h00;
            r_done     <= 1'b0;
        end else begin
            r_rd_ptr   <= n_rd_ptr;
            r_wr_ptr   <= n_wr_ptr;
            r_if_en    <= n_if_en;
            r_led_pend <= n_led_pend;
            r_sysctl   <= n_sysctl;
            r_done     <= i_dp_cmd.execute;
        end
    end

    kbq_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (enq_byte),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    assign o_done         = r_done;
    assign o_read_data    = r_read_data;
    assign o_irq_assert   = r_irq_assert;
    assign o_irq_clear    = r_irq_clear;
    assign o_gate_update  = r_gate_update;
    assign o_timer_gate   = r_sysctl[0];
    assign o_speaker_on   = r_sysctl[1];
    assign o_byte_dropped = r_byte_dropped;

endmodule
`default_nettype wire

[design/keyboard_controller_byte_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Keyboard controller byte queue
// The result strobe is registered from the execute state that follows the
// request transfer. A new request is taken only when idle; busy is high in
// the execute state, which waits on the registered read of the queue RAM at
// the read pointer. Each result is shown for one cycle only, as the receiver
// cannot stall. Synchronous reset empties the queue, enables the interface and
// clears the system control byte; the queue RAM contents are not cleared.
// ----------------------------------------------------------------------------
module keyboard_controller_byte_queue #(
    parameter int QUEUE_DEPTH = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire logic [1:0] i_command,
    input  wire logic [2:0] i_port_offset,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_speaker_active,
    output logic            o_done,
    output logic      [7:0] o_read_data,
    output logic            o_irq_assert,
    output logic            o_irq_clear,
    output logic            o_gate_update,
    output logic            o_timer_gate,
    output logic            o_speaker_on,
    output logic            o_byte_dropped
);
    import kbq_pkg::*;

    t_dp_cmd dp_cmd;

    kbq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_dp_cmd (dp_cmd)
    );

    kbq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_dp_cmd         (dp_cmd),
        .i_command        (i_command),
        .i_port_offset    (i_port_offset),
        .i_data_byte      (i_data_byte),
        .i_speaker_active (i_speaker_active),
        .o_done           (o_done),
        .o_read_data      (o_read_data),
        .o_irq_assert     (o_irq_assert),
        .o_irq_clear      (o_irq_clear),
        .o_gate_update    (o_gate_update),
        .o_timer_gate     (o_timer_gate),
        .o_speaker_on     (o_speaker_on),
        .o_byte_dropped   (o_byte_dropped)
    );

    a_done_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("Result strobe without a request transfer two cycles earlier.");

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("Execute phase lasted longer than one cycle.");

    a_pulses_need_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_irq_assert || o_irq_clear || o_gate_update || o_byte_dropped) |-> o_done)
        else $error("Result pulse outside a result cycle.");

    a_irq_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_irq_assert && o_irq_clear))
        else $error("Interrupt raised and cleared by the same request.");

endmodule
`default_nettype wire
